>>> hw/rtl/lookahead_peak_limiter_core_assert.svh
// assertion macros used by the limiter core rtl
`ifndef LOOKAHEAD_PEAK_LIMITER_CORE_ASSERT_SVH
`define LOOKAHEAD_PEAK_LIMITER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define LPL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LPL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/lpl_pkg.sv
package lpl_pkg;

  localparam logic [16:0] UNITY_GAIN = 17'h10000;
  localparam int          CFG_IDX_W  = 3;
  localparam int          CFG_DATA_W = 26;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LP_B0     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LP_B1     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LP_A1     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LP_A2     = 3'd7;

  typedef struct packed {
    logic signed [25:0] b0;
    logic signed [25:0] b1;
    logic signed [25:0] a1;
    logic signed [25:0] a2;
  } lpl_coef_t;

  // round half away from zero, drop 22 fraction bits
  function automatic logic signed [36:0] rnd_q22(input logic signed [57:0] v);
    logic [57:0] mag;
    logic [57:0] r;
    mag = v[57] ? 58'(-v) : 58'(v);
    r   = (mag + 58'(1 << 21)) >> 22;
    return v[57] ? -$signed({1'b0, r[35:0]}) : $signed({1'b0, r[35:0]});
  endfunction

  // round half away from zero, drop 16 fraction bits
  function automatic logic signed [26:0] rnd_q16(input logic signed [41:0] v);
    logic [41:0] mag;
    logic [41:0] r;
    mag = v[41] ? 42'(-v) : 42'(v);
    r   = (mag + 42'(1 << 15)) >> 16;
    return v[41] ? -$signed({1'b0, r[25:0]}) : $signed({1'b0, r[25:0]});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    if (v > 27'sd8388607) begin
      return 24'sh7fffff;
    end else if (v < -27'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

endpackage

>>> hw/rtl/lpl_if.sv
interface lpl_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface lpl_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample_out;
  logic [16:0]        applied_gain;
  logic [22:0]        peak_level;
  modport source (output valid, output sample_out, output applied_gain,
                  output peak_level, input ready);
  modport sink   (input valid, input sample_out, input applied_gain,
                  input peak_level, output ready);
endinterface

>>> hw/rtl/lookahead_peak_limiter_core.sv
// channel | dir | payload                                   | accepted when
// in_ch   | in  | sample_in                                 | valid && ready
// out_ch  | out | sample_out, applied_gain, peak_level      | valid && ready
// cfg_    | in  | cfg_idx, cfg_wdata                        | cfg_we high
//
// one sample at a time with limiting on: filter pass, a divide when the peak
// exceeds the threshold, ring update, window sweep (L = window length; L = 0
// skips it), a second release step when the gain releases, multiply and round.
// the window minimum sweeps the gain memory at one read per cycle.
// bypass samples go from acceptance to S_OUT, then into the output register.
// after reset a clearing sweep over all MAX_LOOKAHEAD entries fills both memories
// before in_ch.ready rises. a finished result waits in the output register
// while the next sample is taken in.
module lookahead_peak_limiter_core
  import lpl_pkg::*;
#(
  parameter int MAX_LOOKAHEAD = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lpl_in_if.sink                in_ch,
  lpl_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  `include "lookahead_peak_limiter_core_assert.svh"

  localparam int AW = (MAX_LOOKAHEAD > 1) ? $clog2(MAX_LOOKAHEAD) : 1;
  localparam int LW = $clog2(MAX_LOOKAHEAD + 1);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_FILT  = 11'b00000000100,
    S_DIV   = 11'b00000001000,
    S_RING  = 11'b00000010000,
    S_SWEEP = 11'b00000100000,
    S_REL1  = 11'b00001000000,
    S_REL2  = 11'b00010000000,
    S_MUL   = 11'b00100000000,
    S_RND   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic        en_r;
  logic [22:0] thr_r;
  logic [15:0] rel_r;
  logic [8:0]  len_cfg_r;
  lpl_coef_t   coef_r;

  // per-sample state
  logic signed [23:0] x_r;
  logic signed [23:0] last_r;
  logic signed [23:0] mid_r;
  logic signed [23:0] delayed_r;
  logic [22:0]        peak_r;
  logic [16:0]        req_r;
  logic [16:0]        min_r;
  logic [16:0]        target_r;
  logic [16:0]        gain_r;
  logic [32:0]        acc_r;
  logic signed [41:0] mul_r;
  logic [AW-1:0]      ring_pos_r;
  logic [AW-1:0]      clr_cnt_r;
  logic [LW-1:0]      cnt_r;
  logic               filt_start_r;
  logic signed [23:0] res_sample_r;
  logic [16:0]        res_gain_r;
  logic [22:0]        res_peak_r;

  // output register
  logic               out_valid_r;
  logic signed [23:0] out_sample_r;
  logic [16:0]        out_gain_r;
  logic [22:0]        out_peak_r;

  // memories
  logic signed [23:0] dly_mem [MAX_LOOKAHEAD];
  logic [16:0]        gain_mem [MAX_LOOKAHEAD];
  logic signed [23:0] dly_rdata_r;
  logic [16:0]        gain_rdata_r;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic signed [23:0] dly_wd;
  logic [16:0]        gain_wd;

  logic               accept;
  logic [LW-1:0]      len;
  logic [AW-1:0]      pos;
  logic [AW-1:0]      pos_next;
  logic signed [24:0] msum;
  logic [24:0]        mmag;
  logic [24:0]        mhalf;
  logic signed [23:0] mid_val;
  logic               filt_done;
  logic [22:0]        filt_peak;
  logic               div_start;
  logic               div_done;
  logic [15:0]        div_q;
  logic [16:0]        min_new;
  logic [33:0]        rel_term;
  logic [34:0]        rel_sum;
  logic [18:0]        rel_sh;
  logic               out_free;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign len = (32'(len_cfg_r) > MAX_LOOKAHEAD) ? LW'(MAX_LOOKAHEAD) : LW'(len_cfg_r);
  assign pos = (LW'(ring_pos_r) >= len) ? '0 : ring_pos_r;
  assign pos_next = (LW'(pos) + LW'(1) == len) ? '0 : AW'(LW'(pos) + LW'(1));

  // rounded midpoint with the previous sample
  assign msum    = 25'(in_ch.sample_in) + 25'(last_r);
  assign mmag    = msum[24] ? 25'(-msum) : 25'(msum);
  assign mhalf   = (mmag + 25'd1) >> 1;
  assign mid_val = msum[24] ? 24'(-$signed(mhalf)) : 24'(mhalf);

  assign min_new = ((cnt_r != '0) && (gain_rdata_r < min_r)) ? gain_rdata_r : min_r;

  assign rel_term = (34'(UNITY_GAIN) - 34'(rel_r)) * 34'(target_r);
  assign rel_sum  = 35'(acc_r) + 35'(rel_term) + 35'd32768;
  assign rel_sh   = rel_sum[34:16];

  assign div_start = (state_r == S_FILT) && filt_done && (filt_peak > thr_r);

  lpl_filter u_filter (
    .clk   (clk),
    .rst_n (rst_n),
    .start (filt_start_r),
    .mid   (mid_r),
    .smp   (x_r),
    .coef  (coef_r),
    .done  (filt_done),
    .peak  (filt_peak)
  );

  lpl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (thr_r),
    .den   (filt_peak),
    .done  (div_done),
    .quot  (div_q)
  );

  // memory write side: clearing sweep or ring update
  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = pos;
    dly_wd  = x_r;
    gain_wd = req_r;
    if (state_r == S_CLEAR) begin
      mem_we  = 1'b1;
      mem_wa  = clr_cnt_r;
      dly_wd  = '0;
      gain_wd = UNITY_GAIN;
    end else if ((state_r == S_RING) && (len != '0)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dly_mem[mem_wa]  <= dly_wd;
      gain_mem[mem_wa] <= gain_wd;
    end
    dly_rdata_r  <= dly_mem[pos];
    gain_rdata_r <= gain_mem[cnt_r[AW-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == AW'(MAX_LOOKAHEAD - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = en_r ? S_FILT : S_OUT;
      S_FILT:  if (filt_done) state_nxt = (filt_peak > thr_r) ? S_DIV : S_RING;
      S_DIV:   if (div_done) state_nxt = S_RING;
      S_RING:  state_nxt = (len == '0) ? S_REL1 : S_SWEEP;
      S_SWEEP: if (cnt_r == len) state_nxt = S_REL1;
      S_REL1:  state_nxt = (target_r < gain_r) ? S_MUL : S_REL2;
      S_REL2:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_RND;
      S_RND:   state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      filt_start_r <= 1'b0;
      out_valid_r  <= 1'b0;
      en_r         <= 1'b1;
      thr_r        <= 23'd1048576;
      rel_r        <= 16'd65000;
      len_cfg_r    <= 9'd64;
      coef_r.b0    <= 26'sd4194304;
      coef_r.b1    <= '0;
      coef_r.a1    <= '0;
      coef_r.a2    <= '0;
      ring_pos_r   <= '0;
      gain_r       <= UNITY_GAIN;
      last_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      filt_start_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_idx)
          REG_ENABLE:    en_r      <= cfg_wdata[0];
          REG_THRESHOLD: thr_r     <= cfg_wdata[22:0];
          REG_RELEASE:   rel_r     <= cfg_wdata[15:0];
          REG_LOOKAHEAD: len_cfg_r <= cfg_wdata[8:0];
          REG_LP_B0:     coef_r.b0 <= $signed(cfg_wdata);
          REG_LP_B1:     coef_r.b1 <= $signed(cfg_wdata);
          REG_LP_A1:     coef_r.a1 <= $signed(cfg_wdata);
          REG_LP_A2:     coef_r.a2 <= $signed(cfg_wdata);
        endcase
      end

      // a reload in S_OUT takes precedence over the clear
      if (out_valid_r && out_ch.ready && !((state_r == S_OUT) && out_free)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLEAR: clr_cnt_r <= clr_cnt_r + AW'(1);
        S_IDLE: begin
          if (accept) begin
            x_r <= in_ch.sample_in;
            if (en_r) begin
              mid_r        <= mid_val;
              last_r       <= in_ch.sample_in;
              filt_start_r <= 1'b1;
            end else begin
              res_sample_r <= in_ch.sample_in;
              res_gain_r   <= UNITY_GAIN;
              res_peak_r   <= '0;
            end
          end
        end
        S_FILT: begin
          if (filt_done) begin
            peak_r <= filt_peak;
            req_r  <= UNITY_GAIN;
          end
        end
        S_DIV: if (div_done) req_r <= {1'b0, div_q};
        S_RING: begin
          cnt_r <= '0;
          min_r <= UNITY_GAIN;
          if (len == '0) begin
            delayed_r <= x_r;
            target_r  <= req_r;
          end else begin
            ring_pos_r <= pos_next;
          end
        end
        S_SWEEP: begin
          // first cycle also brings back the delayed sample
          if (cnt_r == '0) delayed_r <= dly_rdata_r;
          min_r    <= min_new;
          target_r <= min_new;
          cnt_r    <= cnt_r + LW'(1);
        end
        S_REL1: begin
          if (target_r < gain_r) begin
            gain_r <= target_r;
          end else begin
            acc_r <= 33'(rel_r) * 33'(gain_r);
          end
        end
        S_REL2: gain_r <= (rel_sh > 19'(UNITY_GAIN)) ? UNITY_GAIN : rel_sh[16:0];
        S_MUL: mul_r <= 42'(delayed_r) * 42'($signed({1'b0, gain_r}));
        S_RND: begin
          res_sample_r <= sat24(rnd_q16(mul_r));
          res_gain_r   <= gain_r;
          res_peak_r   <= peak_r;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= res_sample_r;
            out_gain_r   <= res_gain_r;
            out_peak_r   <= res_peak_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.sample_out   = out_sample_r;
  assign out_ch.applied_gain = out_gain_r;
  assign out_ch.peak_level   = out_peak_r;

  `LPL_ASSERT_IMP(a_filt_done_state, filt_done, state_r == S_FILT, "filter done outside filter wait")
  `LPL_ASSERT_IMP(a_div_done_state, div_done, state_r == S_DIV, "divider done outside divide wait")
  `LPL_ASSERT_NXT(a_bypass_path, accept && !en_r, state_r == S_OUT, "bypass sample not sent to output")
  `LPL_ASSERT_IMP(a_gain_limit, out_valid_r, out_gain_r <= UNITY_GAIN, "applied gain above unity")

endmodule

>>> hw/rtl/lpl_div.sv
module lpl_div
  import lpl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [22:0] num,
  input  logic [22:0] den,
  output logic        done,
  output logic [15:0] quot
);

  // restoring division of num*65536 by den, valid while num < den
  logic [22:0] rem_r;
  logic [22:0] den_r;
  logic [15:0] q_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [23:0] r2;
  logic        ge;

  assign r2 = {rem_r, 1'b0};
  assign ge = r2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd16;
        rem_r  <= num;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= ge ? 23'(r2 - {1'b0, den_r}) : r2[22:0];
        q_r   <= {q_r[14:0], ge};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

>>> hw/rtl/lpl_filter.sv
module lpl_filter
  import lpl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [23:0] mid,
  input  logic signed [23:0] smp,
  input  lpl_coef_t          coef,
  output logic               done,
  output logic [22:0]        peak
);

  // four biquad passes: mid through both sections, then the sample
  logic [1:0]         pass_r;
  logic [2:0]         step_r;
  logic               busy_r;
  logic               done_r;
  logic signed [31:0] xin_r;
  logic signed [31:0] y_r;
  logic signed [36:0] bx_r;
  logic signed [39:0] t_r;
  logic signed [57:0] prod_r;
  logic signed [31:0] z1_r [2];
  logic signed [31:0] z2_r [2];
  logic [22:0]        p0_r;
  logic [22:0]        peak_r;

  logic               sec;
  logic signed [31:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [57:0] mul_p;
  logic signed [36:0] prnd;
  logic signed [39:0] ysum;
  logic signed [32:0] ye;
  logic [32:0]        ymag;
  logic [22:0]        ysat;

  assign sec   = pass_r[0];
  assign mul_a = (step_r < 3'd2) ? xin_r : y_r;
  assign prnd  = rnd_q22(prod_r);
  assign ysum  = 40'(prnd) + 40'(z1_r[sec]);

  always_comb begin
    unique case (step_r[1:0])
      2'd0: mul_b = coef.b0;
      2'd1: mul_b = coef.b1;
      2'd2: mul_b = coef.a1;
      2'd3: mul_b = coef.a2;
    endcase
  end

  assign mul_p = 58'(mul_a) * 58'(mul_b);

  assign ye   = 33'(y_r);
  assign ymag = ye[32] ? 33'(-ye) : 33'(ye);
  assign ysat = (ymag > 33'd8388607) ? 23'h7fffff : ymag[22:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      pass_r  <= '0;
      step_r  <= '0;
      z1_r[0] <= '0;
      z1_r[1] <= '0;
      z2_r[0] <= '0;
      z2_r[1] <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        pass_r <= '0;
        step_r <= '0;
        xin_r  <= 32'(mid);
      end else if (busy_r) begin
        if (step_r != 3'd4) begin
          prod_r <= mul_p;
        end
        unique case (step_r)
          3'd0: step_r <= 3'd1;
          3'd1: begin
            bx_r   <= prnd;
            y_r    <= sat32(ysum);
            step_r <= 3'd2;
          end
          3'd2: begin
            t_r    <= 40'(prnd);
            step_r <= 3'd3;
          end
          3'd3: begin
            t_r    <= t_r - 40'(prnd) + 40'(z2_r[sec]);
            step_r <= 3'd4;
          end
          3'd4: begin
            z1_r[sec] <= sat32(t_r);
            z2_r[sec] <= sat32(40'(bx_r) - 40'(prnd));
            step_r    <= '0;
            pass_r    <= pass_r + 2'd1;
            unique case (pass_r)
              2'd0: xin_r <= y_r;
              2'd1: begin
                p0_r  <= ysat;
                xin_r <= 32'(smp);
              end
              2'd2: xin_r <= y_r;
              2'd3: begin
                peak_r <= (p0_r > ysat) ? p0_r : ysat;
                busy_r <= 1'b0;
                done_r <= 1'b1;
              end
            endcase
          end
          default: step_r <= '0;
        endcase
      end
    end
  end

  assign done = done_r;
  assign peak = peak_r;

endmodule
